// ===== rtl/gts_pkg.sv =====
`default_nettype none

package gts_pkg;

   localparam int QUARTER_ENTRIES = 128;
   localparam int INDEX_W         = $clog2(QUARTER_ENTRIES);

   localparam int TARGET_W   = 24;
   localparam int PHASE_W    = 32;
   localparam int SLOPE_W    = 25;
   localparam int GAIN_W     = 8;
   localparam int COUNT_W    = 17;
   localparam int SAMPLE_W   = 8;
   localparam int RAMP_W     = 16;
   localparam int TOP_W      = 16;
   localparam int INTERVAL_W = 10;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam int DIVIDEND_W = TARGET_W;
   localparam int DIVISOR_W  = RAMP_W;
   localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);

   localparam logic [PHASE_W-1:0]    PHASE_RESET    = 32'd384 << 16;
   localparam logic [GAIN_W-1:0]     GAIN_START     = 8'd64;
   localparam logic [GAIN_W-1:0]     GAIN_TOP       = 8'd128;
   localparam logic [RAMP_W-1:0]     RAMP_RESET     = 16'd256;
   localparam logic [TOP_W-1:0]      TOP_RESET      = 16'd1024;
   localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 10'd4;

   localparam logic [SAMPLE_W-1:0] SINE_TABLE [QUARTER_ENTRIES] = '{
      8'd128, 8'd129, 8'd131, 8'd132, 8'd134, 8'd135, 8'd137, 8'd138,
      8'd140, 8'd142, 8'd143, 8'd145, 8'd146, 8'd148, 8'd149, 8'd151,
      8'd152, 8'd154, 8'd156, 8'd157, 8'd159, 8'd160, 8'd162, 8'd163,
      8'd165, 8'd166, 8'd168, 8'd169, 8'd171, 8'd172, 8'd174, 8'd175,
      8'd176, 8'd178, 8'd179, 8'd181, 8'd182, 8'd184, 8'd185, 8'd186,
      8'd188, 8'd189, 8'd191, 8'd192, 8'd193, 8'd195, 8'd196, 8'd197,
      8'd199, 8'd200, 8'd201, 8'd202, 8'd204, 8'd205, 8'd206, 8'd207,
      8'd209, 8'd210, 8'd211, 8'd212, 8'd213, 8'd215, 8'd216, 8'd217,
      8'd218, 8'd219, 8'd220, 8'd221, 8'd222, 8'd223, 8'd224, 8'd225,
      8'd226, 8'd227, 8'd228, 8'd229, 8'd230, 8'd231, 8'd232, 8'd233,
      8'd234, 8'd235, 8'd236, 8'd236, 8'd237, 8'd238, 8'd239, 8'd240,
      8'd240, 8'd241, 8'd242, 8'd243, 8'd243, 8'd244, 8'd245, 8'd245,
      8'd246, 8'd246, 8'd247, 8'd247, 8'd248, 8'd249, 8'd249, 8'd250,
      8'd250, 8'd250, 8'd251, 8'd251, 8'd252, 8'd252, 8'd252, 8'd253,
      8'd253, 8'd253, 8'd254, 8'd254, 8'd254, 8'd254, 8'd255, 8'd255,
      8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255
   };

   typedef enum logic [1:0] {
      REG_RAMP_LEN,
      REG_TOP_LEN,
      REG_AMP_INTERVAL
   } reg_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_LOOKUP,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic accept;
      logic lookup;
      logic emit;
   } command_type;

   typedef struct packed {
      logic div_done;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

// ===== rtl/gts_divider.sv =====
`default_nettype none

module gts_divider (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   input  wire logic [gts_pkg::DIVIDEND_W-1:0]   dividend,
   input  wire logic [gts_pkg::DIVISOR_W-1:0]    divisor,
   output logic      [gts_pkg::DIVIDEND_W-1:0]   quotient,
   output logic      [gts_pkg::DIVISOR_W-1:0]    remainder,
   output logic                                  done
);

   localparam int NW = gts_pkg::DIVIDEND_W;
   localparam int DW = gts_pkg::DIVISOR_W;
   localparam int CW = gts_pkg::DIV_CNT_W;
   localparam logic [CW-1:0] LAST_STEP = CW'(NW - 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [NW-1:0] quo_ff, quo_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [DW-1:0] divisor_ff, divisor_in;
   logic [DW:0]   shifted;
   logic [DW+1:0] trial;

   // one restoring step: shift in the next dividend bit, subtract if it fits
   always_comb begin
      shifted    = {rem_ff, quo_ff[NW-1]};
      trial      = {1'b0, shifted} - {2'b00, divisor_ff};
      busy_in    = busy_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      if (start) begin
         busy_in    = 1'b1;
         cnt_in     = '0;
         quo_in     = dividend;
         rem_in     = '0;
         divisor_in = divisor;
      end else if (busy_ff) begin
         if (!trial[DW+1]) begin
            rem_in = trial[DW-1:0];
            quo_in = {quo_ff[NW-2:0], 1'b1};
         end else begin
            rem_in = shifted[DW-1:0];
            quo_in = {quo_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign quotient  = quo_ff;
   assign remainder = rem_ff;
   assign done      = done_ff;

`ifndef SYNTHESIS
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff && $past(busy_ff))
      else $error("divider done without a running division");
   a_start_clears_done: assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff && !done_ff)
      else $error("divider start did not begin a division");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff <= LAST_STEP)
      else $error("divider step count out of range");
`endif

endmodule

`default_nettype wire

// ===== rtl/gts_datapath.sv =====
`default_nettype none

module gts_datapath (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire gts_pkg::command_type              cmd,
   output gts_pkg::status_type                    status,
   input  wire logic [gts_pkg::TARGET_W-1:0]      target_step,
   input  wire logic                              message_start,
   output logic      [gts_pkg::SAMPLE_W-1:0]      sample,
   output logic                                   frame_end,
   output logic                                   out_valid,
   input  wire logic                              out_ready,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [gts_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire logic [gts_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic      [gts_pkg::CSR_DATA_W-1:0]    csr_prdata
);

   localparam int TW = gts_pkg::TARGET_W;
   localparam int PW = gts_pkg::PHASE_W;
   localparam int SW = gts_pkg::SLOPE_W;
   localparam int GW = gts_pkg::GAIN_W;
   localparam int CW = gts_pkg::COUNT_W;
   localparam int RW = gts_pkg::RAMP_W;
   localparam int OW = gts_pkg::TOP_W;
   localparam int IW = gts_pkg::INTERVAL_W;
   localparam int XW = gts_pkg::INDEX_W;
   localparam int AW = gts_pkg::SAMPLE_W;

   // configuration registers
   logic [RW-1:0] ramp_len_ff;
   logic [OW-1:0] top_len_ff;
   logic [IW-1:0] amp_interval_ff;
   logic          csr_write;
   gts_pkg::reg_index_type csr_index;

   assign csr_write = csr_psel && csr_penable && csr_pwrite;
   assign csr_index = gts_pkg::reg_index_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         ramp_len_ff     <= gts_pkg::RAMP_RESET;
         top_len_ff      <= gts_pkg::TOP_RESET;
         amp_interval_ff <= gts_pkg::INTERVAL_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            gts_pkg::REG_RAMP_LEN:     ramp_len_ff     <= csr_pwdata[RW-1:0];
            gts_pkg::REG_TOP_LEN:      top_len_ff      <= csr_pwdata[OW-1:0];
            gts_pkg::REG_AMP_INTERVAL: amp_interval_ff <= csr_pwdata[IW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         gts_pkg::REG_RAMP_LEN:     csr_prdata = {{(32-RW){1'b0}}, ramp_len_ff};
         gts_pkg::REG_TOP_LEN:      csr_prdata = {{(32-OW){1'b0}}, top_len_ff};
         gts_pkg::REG_AMP_INTERVAL: csr_prdata = {{(32-IW){1'b0}}, amp_interval_ff};
         default:                   csr_prdata = '0;
      endcase
   end

   // synthesis state
   logic [PW-1:0] phase_ff, phase_in;
   logic [PW-1:0] cur_step_ff, cur_step_in;
   logic [TW-1:0] prev_target_ff, prev_target_in;
   logic [SW-1:0] slope_ff, slope_in;
   logic [GW-1:0] gain_ff, gain_in;
   logic [CW-1:0] count_ff, count_in;
   logic          frame_start_ff, frame_start_in;
   logic          negative_ff, negative_in;
   logic [AW-1:0] value_ff, value_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [AW-1:0] rsp_data_ff, rsp_data_in;
   logic          rsp_last_ff, rsp_last_in;

   logic          at_start;
   logic [TW-1:0] base;
   logic [TW:0]   diff;
   logic [TW:0]   magnitude;
   logic [IW-1:0] interval;
   logic          div_start;
   logic [gts_pkg::DIVIDEND_W-1:0] div_dividend;
   logic [gts_pkg::DIVISOR_W-1:0]  div_divisor;
   logic [gts_pkg::DIVIDEND_W-1:0] div_quotient;
   logic [gts_pkg::DIVISOR_W-1:0]  div_remainder;
   logic          div_done;

   logic [AW-1:0] ph;
   logic [XW-1:0] table_index;
   logic [AW-1:0] table_value;
   logic [2*AW-1:0] product;
   logic          in_ramp;
   logic          gain_tick;
   logic [CW:0]   count_next;
   logic [CW:0]   frame_total;
   logic          last;

   assign at_start  = (count_ff == '0);
   assign base      = (message_start || prev_target_ff == '0) ? target_step : prev_target_ff;
   assign diff      = {1'b0, target_step} - {1'b0, base};
   assign magnitude = diff[TW] ? (~diff + 1'b1) : diff;
   assign interval  = (amp_interval_ff == '0) ? IW'(1) : amp_interval_ff;

   // frame start divides the glide, other ticks take count mod interval
   assign div_start    = cmd.accept;
   assign div_dividend = at_start ? magnitude[TW-1:0]
                                  : {{(gts_pkg::DIVIDEND_W-CW){1'b0}}, count_ff};
   assign div_divisor  = at_start ? ramp_len_ff
                                  : {{(gts_pkg::DIVISOR_W-IW){1'b0}}, interval};

   gts_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .quotient  (div_quotient),
      .remainder (div_remainder),
      .done      (div_done)
   );

   // quarter-wave lookup: mirror on bit 23, invert the negative half on bit 24
   assign ph          = phase_ff[23:16];
   assign table_index = ph[AW-1] ? ~ph[XW-1:0] : ph[XW-1:0];
   assign table_value = phase_ff[24] ? ~gts_pkg::SINE_TABLE[table_index]
                                     : gts_pkg::SINE_TABLE[table_index];
   assign product     = value_ff * gain_ff;

   assign in_ramp     = (count_ff < {1'b0, ramp_len_ff});
   assign gain_tick   = frame_start_ff || (div_remainder == '0);
   assign count_next  = {1'b0, count_ff} + 1'b1;
   assign frame_total = {2'b00, ramp_len_ff} + {2'b00, top_len_ff};
   assign last        = (count_next >= frame_total);

   always_comb begin
      phase_in       = phase_ff;
      cur_step_in    = cur_step_ff;
      prev_target_in = prev_target_ff;
      slope_in       = slope_ff;
      gain_in        = gain_ff;
      count_in       = count_ff;
      frame_start_in = frame_start_ff;
      negative_in    = negative_ff;
      value_in       = value_ff;
      rsp_valid_in   = rsp_valid_ff && !out_ready;
      rsp_data_in    = rsp_data_ff;
      rsp_last_in    = rsp_last_ff;

      if (cmd.accept) begin
         frame_start_in = at_start;
         negative_in    = diff[TW];
         if (at_start) begin
            prev_target_in = target_step;
            cur_step_in    = {{(PW-TW){1'b0}}, base};
            gain_in        = gts_pkg::GAIN_START;
         end
      end

      if (cmd.lookup) begin
         value_in = table_value;
         if (frame_start_ff) begin
            if (ramp_len_ff == '0)
               slope_in = '0;
            else if (negative_ff)
               slope_in = ~{1'b0, div_quotient} + 1'b1;
            else
               slope_in = {1'b0, div_quotient};
         end
      end

      if (cmd.emit) begin
         phase_in = phase_ff + cur_step_ff;
         if (in_ramp) begin
            cur_step_in = cur_step_ff + {{(PW-SW){slope_ff[SW-1]}}, slope_ff};
            if (gain_tick && !gain_ff[GW-1])
               gain_in = gain_ff + 1'b1;
         end
         count_in     = last ? '0 : count_next[CW-1:0];
         rsp_valid_in = 1'b1;
         rsp_data_in  = product[2*AW-1:AW];
         rsp_last_in  = last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= gts_pkg::PHASE_RESET;
         cur_step_ff    <= '0;
         prev_target_ff <= '0;
         slope_ff       <= '0;
         gain_ff        <= gts_pkg::GAIN_START;
         count_ff       <= '0;
         frame_start_ff <= 1'b0;
         negative_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         cur_step_ff    <= cur_step_in;
         prev_target_ff <= prev_target_in;
         slope_ff       <= slope_in;
         gain_ff        <= gain_in;
         count_ff       <= count_in;
         frame_start_ff <= frame_start_in;
         negative_ff    <= negative_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      value_ff    <= value_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign status.div_done = div_done;
   assign status.out_free = !rsp_valid_ff || out_ready;

   assign sample    = rsp_data_ff;
   assign frame_end = rsp_last_ff;
   assign out_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_gain_bound: assert property (@(posedge clock) disable iff (reset)
      gain_ff <= gts_pkg::GAIN_TOP)
      else $error("gain above full scale");
   a_emit_room: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !rsp_valid_ff || out_ready)
      else $error("result emitted over an untaken word");
   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      cmd.emit && last |=> count_ff == '0 && rsp_last_ff)
      else $error("frame end did not restart the sample count");
   a_start_gain: assert property (@(posedge clock) disable iff (reset)
      cmd.accept && at_start |=> gain_ff == gts_pkg::GAIN_START)
      else $error("gain not restarted at frame start");
`endif

endmodule

`default_nettype wire

// ===== rtl/gts_controller.sv =====
`default_nettype none

module gts_controller (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire gts_pkg::status_type  status,
   output gts_pkg::command_type      cmd
);

   gts_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         gts_pkg::ST_IDLE:   if (req_tvalid)      state_in = gts_pkg::ST_DIVIDE;
         gts_pkg::ST_DIVIDE: if (status.div_done) state_in = gts_pkg::ST_LOOKUP;
         gts_pkg::ST_LOOKUP:                      state_in = gts_pkg::ST_EMIT;
         gts_pkg::ST_EMIT:   if (status.out_free) state_in = gts_pkg::ST_IDLE;
         default:                                 state_in = gts_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         gts_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
         end
         gts_pkg::ST_LOOKUP: cmd.lookup = 1'b1;
         gts_pkg::ST_EMIT:   cmd.emit   = status.out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gts_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTHESIS
   a_accept_starts_divide: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> state_ff == gts_pkg::ST_DIVIDE)
      else $error("accepted word did not start a division");
   a_one_command: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.accept, cmd.lookup, cmd.emit}))
      else $error("more than one datapath command at once");
   a_emit_returns_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> req_tready)
      else $error("controller not ready after emitting a word");
`endif

endmodule

`default_nettype wire

// ===== rtl/glide_tone_synthesizer.sv =====
`default_nettype none

// An accepted req word passes through the 24-step shared restoring divider
// (glide slope at frame start, gain interval remainder on all other ticks),
// then the lookup and emit steps, before its rsp word is registered.
// A new req word is taken only after the previous rsp word has been emitted.
// Reset: synchronous; phase, step, gain and frame count return to frame start.
module glide_tone_synthesizer (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic [23:0]                    req_tdata,   // [23:0] target_step
   input  wire logic                           req_tuser,   // [0] message_start
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output logic      [7:0]                     rsp_tdata,   // [7:0] sample
   output logic                                rsp_tlast,   // frame_end
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [gts_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [gts_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [gts_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                csr_pready
);

   gts_pkg::command_type cmd;
   gts_pkg::status_type  status;

   assign csr_pready = 1'b1;

   gts_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   gts_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .target_step   (req_tdata),
      .message_start (req_tuser),
      .sample        (rsp_tdata),
      .frame_end     (rsp_tlast),
      .out_valid     (rsp_tvalid),
      .out_ready     (rsp_tready),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata)
   );

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

   localparam int WORD_TARGET = 1900;
   localparam int CYCLE_LIMIT = 1_000_000;

   typedef struct packed {
      bit [7:0] sample;
      bit       frame_end;
   } tone_word_type;

   class tone_scoreboard;
      bit [15:0]     ramp_len;
      bit [15:0]     top_len;
      bit [9:0]      amp_interval;
      bit [31:0]     phase;
      bit [31:0]     step;
      bit [23:0]     last_target;
      int            slope;
      bit [7:0]      gain;
      bit [16:0]     count;
      bit [7:0]      quarter_sine [128];
      tone_word_type due_samples [$];
      int            mismatches;

      function new();
         for (int i = 0; i < 128; i++)
            quarter_sine[i] = 8'($rtoi($floor(128.0 * (1.0 +
                              $sin(2.0 * 3.141592653589793 * i / 512.0)))));
         ramp_len     = 16'd256;
         top_len      = 16'd1024;
         amp_interval = 10'd4;
         phase        = 32'd384 << 16;
         step         = '0;
         last_target  = '0;
         slope        = 0;
         gain         = 8'd64;
         count        = '0;
         mismatches   = 0;
      endfunction

      function void set_reg(gts_pkg::reg_index_type idx, bit [31:0] value);
         case (idx)
            gts_pkg::REG_RAMP_LEN:     ramp_len = value[15:0];
            gts_pkg::REG_TOP_LEN:      top_len = value[15:0];
            gts_pkg::REG_AMP_INTERVAL: amp_interval = value[9:0];
            default: ;
         endcase
      endfunction

      function void flag(string what, bit [31:0] expected, bit [31:0] actual);
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch %s: expected %0h, got %0h", what, expected, actual);
      endfunction

      function int pending();
         return due_samples.size();
      endfunction

      // Advance the tone state by one tick and queue the word it yields.
      function void note_tick(bit [23:0] target, bit mstart);
         int unsigned   total;
         int unsigned   spacing;
         int unsigned   base;
         bit [7:0]      p;
         bit [7:0]      idx;
         bit [7:0]      level;
         bit [15:0]     product;
         bit            last;
         tone_word_type w;
         total   = 32'(ramp_len) + 32'(top_len);
         spacing = (amp_interval != 0) ? 32'(amp_interval) : 32'd1;
         if (count == 0) begin
            if (mstart)
               last_target = '0;
            base = (last_target != 0) ? 32'(last_target) : 32'(target);
            slope = (ramp_len != 0) ? (int'(target) - int'(base)) / int'(ramp_len) : 0;
            step = base;
            gain = 8'd64;
            last_target = target;
         end
         // mirror within the quarter, invert in the lower half
         p = phase[23:16];
         idx = p[7] ? 8'd255 - p : p;
         level = quarter_sine[idx[6:0]];
         if (phase[24])
            level = 8'd255 - level;
         product = level * gain;
         w.sample = product[15:8];
         phase = phase + step;
         if (count < ramp_len) begin
            step = step + slope;
            if ((count % spacing) == 0 && !gain[7])
               gain = gain + 8'd1;
         end
         last = (count + 1 >= total);
         count = last ? '0 : count + 17'd1;
         w.frame_end = last;
         due_samples.push_back(w);
      endfunction

      function void check_sample(bit [7:0] sample, bit frame_end);
         tone_word_type w;
         if (due_samples.size() == 0) begin
            flag("unexpected word", 32'd0, 32'({sample, frame_end}));
            return;
         end
         w = due_samples.pop_front();
         if (w.sample != sample)
            flag("sample", 32'(w.sample), 32'(sample));
         if (w.frame_end != frame_end)
            flag("frame_end", 32'(w.frame_end), 32'(frame_end));
      endfunction
   endclass

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [23:0]                    req_tdata = '0;   // [23:0] target_step
   logic                           req_tuser = 1'b0; // [0] message_start
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [7:0]                     rsp_tdata;        // [7:0] sample
   logic                           rsp_tlast;
   logic                           csr_psel = 1'b0;
   logic                           csr_penable = 1'b0;
   logic                           csr_pwrite = 1'b0;
   logic [gts_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [gts_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [gts_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                           csr_pready;

   tone_scoreboard tones = new();
   int             words_sent = 0;
   int             cycles = 0;
   bit             sender_steady = 1'b0;
   bit             receiver_steady = 1'b0;

   localparam bit [24:0] FIRST_WORDS [12] = '{
      {1'b1, 24'h000000}, {1'b0, 24'hFFFFFF}, {1'b0, 24'h000000}, {1'b0, 24'h000001},
      {1'b0, 24'hFFFFFF}, {1'b1, 24'h800000}, {1'b0, 24'h7FFFFF}, {1'b0, 24'h555555},
      {1'b1, 24'hAAAAAA}, {1'b0, 24'hFFFFFF}, {1'b0, 24'hFFFFFE}, {1'b0, 24'h000100}
   };

   glide_tone_synthesizer uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("[glide_tone_synthesizer] ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         tones.check_sample(rsp_tdata, rsp_tlast);
   end

   // Result side: unless receiver_steady is set, stall a random number of cycles before each word.
   initial begin
      int pause;
      @(posedge clock);
      forever begin
         pause = receiver_steady ? 0 : $urandom_range(0, 13);
         if (pause > 0) begin
            rsp_tready <= 1'b0;
            repeat (pause) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   task automatic send_word(bit [23:0] target, bit mstart);
      int gap;
      gap = sender_steady ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= target;
      req_tuser  <= mstart;
      do @(posedge clock); while (!req_tready);
      tones.note_tick(target, mstart);
      words_sent++;
   endtask

   // Hold off the sender until every outstanding word has come back.
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (tones.pending() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(gts_pkg::reg_index_type idx, bit [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      tones.set_reg(idx, value);
      @(posedge clock);
   endtask

   task automatic csr_check(gts_pkg::reg_index_type idx, bit [31:0] expected);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== expected)
         tones.flag("register read", expected, csr_prdata);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_settings(bit [15:0] ramp, bit [15:0] top, bit [9:0] spacing);
      csr_write(gts_pkg::REG_RAMP_LEN, 32'(ramp));
      csr_write(gts_pkg::REG_TOP_LEN, 32'(top));
      csr_write(gts_pkg::REG_AMP_INTERVAL, 32'(spacing));
      csr_check(gts_pkg::REG_RAMP_LEN, 32'(ramp));
      csr_check(gts_pkg::REG_TOP_LEN, 32'(top));
      csr_check(gts_pkg::REG_AMP_INTERVAL, 32'(spacing));
   endtask

   initial begin
      int        phase_no;
      int        count;
      bit [15:0] ramp;
      bit [15:0] top;
      bit [9:0]  spacing;
      bit [23:0] target;
      bit        mstart;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      csr_check(gts_pkg::REG_RAMP_LEN, 32'd256);
      csr_check(gts_pkg::REG_TOP_LEN, 32'd1024);
      csr_check(gts_pkg::REG_AMP_INTERVAL, 32'd4);

      // default frame; a message start inside the frame is ignored
      send_word(24'hFFFFFF, 1'b1);
      send_word(24'h000000, 1'b1);
      send_word(24'h123456, 1'b0);
      drain();

      // shrink the frame mid-way: one-sample frames, zero gain interval
      apply_settings(16'd1, 16'd0, 10'd0);
      foreach (FIRST_WORDS[i])
         send_word(FIRST_WORDS[i][23:0], FIRST_WORDS[i][24]);
      drain();

      // zero frame length
      apply_settings(16'd0, 16'd0, 10'd1);
      send_word(24'h00ABCD, 1'b0);
      send_word(24'hFFFFFF, 1'b1);
      send_word(24'h000000, 1'b0);
      send_word(24'h3C3C3C, 1'b0);
      drain();

      phase_no = 0;
      while (words_sent < WORD_TARGET) begin
         case (phase_no)
            0: begin ramp = 16'hFFFF; top = 16'hFFFF; spacing = 10'd1023; end
            1: begin ramp = 16'hFFFF; top = 16'd0;    spacing = 10'd1;    end
            2: begin ramp = 16'd1;    top = 16'd0;    spacing = 10'd1;    end
            default: begin
               case ($urandom_range(0, 9))
                  0: ramp = 16'hFFFF;
                  1: ramp = 16'd0;
                  2: ramp = 16'($urandom_range(1, 2000));
                  default: ramp = 16'($urandom_range(1, 24));
               endcase
               case ($urandom_range(0, 9))
                  0: top = 16'hFFFF;
                  1, 2: top = 16'd0;
                  3: top = 16'($urandom_range(1, 2000));
                  default: top = 16'($urandom_range(0, 24));
               endcase
               case ($urandom_range(0, 9))
                  0: spacing = 10'd1023;
                  1: spacing = 10'd0;
                  2: spacing = 10'd1;
                  default: spacing = 10'($urandom_range(1, 16));
               endcase
            end
         endcase
         apply_settings(ramp, top, spacing);
         sender_steady   = ($urandom_range(0, 3) == 0);
         receiver_steady = ($urandom_range(0, 3) == 0);
         count = $urandom_range(20, 90);
         repeat (count) begin
            case ($urandom_range(0, 15))
               0: target = 24'h000000;
               1, 2, 3: target = 24'($urandom_range(0, 255));
               default: target = 24'($urandom_range(0, 24'hFFFFFF));
            endcase
            mstart = ($urandom_range(0, 7) == 0);
            send_word(target, mstart);
         end
         drain();
         phase_no++;
      end

      sender_steady   = 1'b0;
      receiver_steady = 1'b0;
      repeat (40) @(posedge clock);
      if (tones.mismatches == 0 && tones.pending() == 0)
         $display("[glide_tone_synthesizer] OK");
      else
         $display("[glide_tone_synthesizer] ERROR");
      $finish;
   end

endmodule
